// ----- src/sstf_pkg.sv -----
// ============================================================================
// sstf_pkg: shared types and constants for the shortest-seek-first scheduler
// Sizes of the request store, field widths, the sequencer states and the
// read tag used by the top level and the scan unit.
// ============================================================================
`timescale 1ns / 1ps

package sstf_pkg;

    // Store geometry
    localparam int MAX_REQUESTS = 32;
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);

    // Field widths
    localparam int TRACK_W = 16;
    localparam int SUM_W   = 21;

    typedef logic [TRACK_W-1:0] track_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [SUM_W-1:0]   sum_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    // Tag that travels with each memory read into the scan unit
    typedef struct packed {
        logic valid;
        logic first;
        idx_t idx;
    } scan_ctl_t;

endpackage

// ----- src/shortest_seek_first_order.sv -----
// ============================================================================
// shortest_seek_first_order: shortest-seek-first track request scheduler
// Loads a batch of track requests into a store, then serves them nearest
// first from the configured head track, one item out per served request.
// ============================================================================
//
//  channel   handshake            payload
//  -------   ------------------   -----------------------------------------
//  input     start && !busy       request_track, batch_end
//  result    done (one cycle)     served_track, move_distance, total_seek,
//                                 final_result
//  config    cfg_write            cfg_data (start_head)
//
//  Loading takes one item per cycle while not busy. Each result takes one
//  store read per remaining entry through the single read port, a wait for
//  the last read word and the swap write-back. No clearing pass after
//  reset. busy is high from the item with batch_end until the final result;
//  results cannot be stalled.
//
`timescale 1ns / 1ps

module shortest_seek_first_order
    import sstf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] request_track,
    input  logic        batch_end,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [15:0] served_track,
    output logic [15:0] move_distance,
    output logic [20:0] total_seek,
    output logic        final_result
);

    // Request store
    track_t    mem [MAX_REQUESTS];
    track_t    rd_data_reg;
    logic      mem_we;
    idx_t      mem_waddr;
    track_t    mem_wdata;

    state_t    state_reg;
    state_t    state_next;
    cnt_t      count_reg;
    cnt_t      count_next;
    idx_t      i_reg;
    idx_t      i_next;
    idx_t      j_reg;
    idx_t      j_next;
    track_t    head_reg;
    track_t    head_next;
    sum_t      sum_reg;
    sum_t      sum_next;
    track_t    start_head_reg;
    scan_ctl_t ctl_reg;
    scan_ctl_t ctl_next;

    logic      done_reg;
    logic      done_next;
    track_t    served_track_reg;
    track_t    served_track_next;
    track_t    move_distance_reg;
    track_t    move_distance_next;
    sum_t      total_seek_reg;
    sum_t      total_seek_next;
    logic      final_result_reg;
    logic      final_result_next;

    track_t    best;
    idx_t      pick;
    track_t    chosen;
    track_t    first_val;

    logic      accept;
    logic      has_room;
    logic      last_read;
    logic      last_pick;
    sum_t      sum_add;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign has_room  = (count_reg < CNT_W'(MAX_REQUESTS));
    assign last_read = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign last_pick = ((CNT_W'(i_reg) + CNT_W'(1)) == count_reg);
    assign sum_add   = sum_reg + SUM_W'(best);

    // Store write port: loading, or moving the pass's first word into the
    // slot of the chosen entry
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = request_track;
        if (accept && has_room)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == ST_UPDATE)
        begin
            mem_we    = 1'b1;
            mem_waddr = pick;
            mem_wdata = first_val;
        end
    end

    // Synchronous memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[j_reg];
    end

    // Minimum search over the read words
    sstf_scan u_scan (
        .clk       (clk),
        .ctl       (ctl_reg),
        .rd_data   (rd_data_reg),
        .head      (head_reg),
        .best      (best),
        .pick      (pick),
        .chosen    (chosen),
        .first_val (first_val)
    );

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        i_next             = i_reg;
        j_next             = j_reg;
        head_next          = head_reg;
        sum_next           = sum_reg;
        ctl_next           = '0;
        done_next          = 1'b0;
        served_track_next  = served_track_reg;
        move_distance_next = move_distance_reg;
        total_seek_next    = total_seek_reg;
        final_result_next  = final_result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (batch_end)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        head_next  = start_head_reg;
                        sum_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                ctl_next.valid = 1'b1;
                ctl_next.first = (j_reg == i_reg);
                ctl_next.idx   = j_reg;
                if (last_read)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                head_next          = chosen;
                sum_next           = sum_add;
                done_next          = 1'b1;
                served_track_next  = chosen;
                move_distance_next = best;
                total_seek_next    = sum_add;
                final_result_next  = last_pick;
                if (last_pick)
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    j_next     = i_reg + IDX_W'(1);
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            head_reg       <= '0;
            sum_reg        <= '0;
            start_head_reg <= '0;
            ctl_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            head_reg  <= head_next;
            sum_reg   <= sum_next;
            ctl_reg   <= ctl_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                start_head_reg <= cfg_data;
            end
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        served_track_reg  <= served_track_next;
        move_distance_reg <= move_distance_next;
        total_seek_reg    <= total_seek_next;
        final_result_reg  <= final_result_next;
    end

    assign done          = done_reg;
    assign served_track  = served_track_reg;
    assign move_distance = move_distance_reg;
    assign total_seek    = total_seek_reg;
    assign final_result  = final_result_reg;

    // Checks
    a_done_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPDATE))
        else $error("result strobe without a preceding update");

    a_batch_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && batch_end) |=> busy)
        else $error("batch end did not start service");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && final_result) |-> (count_reg == '0) && !busy)
        else $error("final result left requests held");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> (pick >= i_reg))
        else $error("chosen slot lies before the pass start");

endmodule

// ----- src/sstf_scan.sv -----
// ============================================================================
// sstf_scan: running minimum over one pass of the request store
// Takes one read word per cycle, keeps the closest track to the head, its
// slot and the word of the pass's first slot (needed for the swap).
// ============================================================================
`timescale 1ns / 1ps

module sstf_scan
    import sstf_pkg::*;
(
    input  logic      clk,
    input  scan_ctl_t ctl,
    input  track_t    rd_data,
    input  track_t    head,
    output track_t    best,
    output idx_t      pick,
    output track_t    chosen,
    output track_t    first_val
);

    track_t best_reg;
    track_t best_next;
    idx_t   pick_reg;
    idx_t   pick_next;
    track_t chosen_reg;
    track_t chosen_next;
    track_t first_val_reg;
    track_t first_val_next;
    track_t gap;

    // Absolute distance from head
    assign gap = (rd_data >= head) ? (rd_data - head) : (head - rd_data);

    // Strict compare keeps the earliest slot on a tie
    always_comb
    begin
        best_next      = best_reg;
        pick_next      = pick_reg;
        chosen_next    = chosen_reg;
        first_val_next = first_val_reg;
        if (ctl.valid)
        begin
            if (ctl.first || (gap < best_reg))
            begin
                best_next   = gap;
                pick_next   = ctl.idx;
                chosen_next = rd_data;
            end
            if (ctl.first)
            begin
                first_val_next = rd_data;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        pick_reg      <= pick_next;
        chosen_reg    <= chosen_next;
        first_val_reg <= first_val_next;
    end

    assign best      = best_reg;
    assign pick      = pick_reg;
    assign chosen    = chosen_reg;
    assign first_val = first_val_reg;

endmodule

// ----- bench/shortest_seek_first_order_test.sv -----
// ============================================================================
// shortest_seek_first_order_test: self-checking bench for the SSTF scheduler
// Loads batches of track requests, mirrors the nearest-first service order in
// a local model and checks every result item field by field as it appears.
// A short table of directed batches runs first, then random batches with
// bursty sender pacing (steady in the last phase) and several start_head settings.
// ============================================================================
`timescale 1ns / 1ps

module shortest_seek_first_order_test;
    import sstf_pkg::*;

    // One served request as the block reports it
    typedef struct packed {
        track_t trk;
        track_t moved;
        sum_t   sum;
        logic   fin;
    } seek_result_t;

    // One row of the directed table
    typedef struct packed {
        logic         wr_cfg;
        track_t       cfg_val;
        track_t       trk;
        logic         last;
        logic         typed;
        seek_result_t res;
    } dir_row_t;

    localparam int DIR_ROWS = 18;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] request_track;
    logic        batch_end;
    logic        cfg_write;
    logic [15:0] cfg_data;
    logic        done;
    logic [15:0] served_track;
    logic [15:0] move_distance;
    logic [20:0] total_seek;
    logic        final_result;

    // Local copy of the scheduler state
    track_t       queued_tracks[MAX_REQUESTS];
    int           queued_count;
    track_t       head_start_shadow;
    seek_result_t service_q[$];
    seek_result_t got_res;
    seek_result_t want_res;
    dir_row_t     dir_tab[DIR_ROWS];

    int errors;
    int burst_left;
    bit quiet;

    shortest_seek_first_order dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request_track (request_track),
        .batch_end     (batch_end),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .done          (done),
        .served_track  (served_track),
        .move_distance (move_distance),
        .total_seek    (total_seek),
        .final_result  (final_result)
    );

    always #4 clk = ~clk;

    function automatic dir_row_t dir_row(logic wr, track_t cv, track_t trk, logic last,
                                         logic typed, track_t et, track_t ed, sum_t es);
        dir_row_t r;
        r.wr_cfg  = wr;
        r.cfg_val = cv;
        r.trk     = trk;
        r.last    = last;
        r.typed   = typed;
        r.res     = '{trk: et, moved: ed, sum: es, fin: typed};
        return r;
    endfunction

    function automatic track_t track_gap(track_t a, track_t b);
        return (a >= b) ? track_t'(a - b) : track_t'(b - a);
    endfunction

    // Store one accepted request; on batch end, work out the service order
    task automatic queue_request(track_t trk, logic last);
        track_t       head;
        track_t       best;
        track_t       d;
        track_t       chosen;
        logic [21:0]  seek;
        int           pick;
        seek_result_t r;
        if (queued_count < MAX_REQUESTS) begin
            queued_tracks[queued_count] = trk;
            queued_count++;
        end
        if (last) begin
            head = head_start_shadow;
            seek = '0;
            for (int i = 0; i < queued_count; i++) begin
                pick = i;
                best = track_gap(queued_tracks[i], head);
                for (int j = i + 1; j < queued_count; j++) begin
                    d = track_gap(queued_tracks[j], head);
                    if (d < best) begin
                        best = d;
                        pick = j;
                    end
                end
                chosen = queued_tracks[pick];
                seek   = seek + best;
                head   = chosen;
                // front remaining entry takes the vacated slot
                queued_tracks[pick] = queued_tracks[i];
                queued_tracks[i]    = chosen;
                r.trk = chosen;
                r.moved = best;
                r.sum = seek[20:0];
                r.fin = (i + 1 == queued_count);
                service_q.push_back(r);
            end
            queued_count = 0;
        end
    endtask

    // Drive one item and hold it until the block takes it
    task automatic send_item(track_t trk, logic last, logic typed, seek_result_t res);
        start         <= 1'b1;
        request_track <= trk;
        batch_end     <= last;
        do @(posedge clk); while (busy);
        if (typed) begin
            queued_count = 0;
            service_q.push_back(res);
        end else begin
            queue_request(trk, last);
        end
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (service_q.size() != 0);
    endtask

    // Register writes only once the block has gone quiet
    task automatic write_start_head(track_t v);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        head_start_shadow = v;
    endtask

    // Bursty sender: random gaps between bursts of random length
    task automatic pace();
        if (!quiet) begin
            if (burst_left == 0) begin
                idle_cycles($urandom_range(1, 12));
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
    endtask

    function automatic track_t pick_track(int mode);
        int v;
        case (mode)
            0: return track_t'($urandom);
            1: return track_t'($urandom_range(0, 15));
            2: begin
                v = $urandom_range(0, 2);
                return (v == 0) ? 16'h0000 : (v == 1) ? 16'hFFFF : track_t'($urandom);
            end
            default: begin
                v = int'(head_start_shadow) + $urandom_range(0, 40) - 20;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return track_t'(v);
            end
        endcase
    endfunction

    task automatic run_batch(int len, output int sent);
        int mode;
        mode = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
            pace();
            send_item(pick_track(mode), k == len - 1, 1'b0, '0);
        end
        sent = len;
    endtask

    // Result checker: the receiver takes every strobe
    always @(posedge clk) begin
        if (rst_n && done) begin
            got_res = '{trk: served_track, moved: move_distance, sum: total_seek,
                        fin: final_result};
            if (service_q.size() == 0) begin
                $display("%0t: result with nothing expected: track %0d dist %0d sum %0d",
                         $time, served_track, move_distance, total_seek);
                errors++;
            end else begin
                want_res = service_q.pop_front();
                if (got_res.trk !== want_res.trk) begin
                    $display("%0t: served_track expected %0d actual %0d",
                             $time, want_res.trk, got_res.trk);
                    errors++;
                end
                if (got_res.moved !== want_res.moved) begin
                    $display("%0t: move_distance expected %0d actual %0d",
                             $time, want_res.moved, got_res.moved);
                    errors++;
                end
                if (got_res.sum !== want_res.sum) begin
                    $display("%0t: total_seek expected %0d actual %0d",
                             $time, want_res.sum, got_res.sum);
                    errors++;
                end
                if (got_res.fin !== want_res.fin) begin
                    $display("%0t: final_result expected %0b actual %0b",
                             $time, want_res.fin, got_res.fin);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("shortest_seek_first_order_test: done, errors");
        $finish;
    end

    // Stimulus
    initial begin
        int sent;
        int len;
        int phase_items;
        track_t phase_head;

        clk               = 1'b0;
        rst_n             = 1'b0;
        start             = 1'b0;
        request_track     = '0;
        batch_end         = 1'b0;
        cfg_write         = 1'b0;
        cfg_data          = '0;
        errors            = 0;
        burst_left        = 0;
        quiet             = 1'b0;
        queued_count      = 0;
        head_start_shadow = '0;

        // single-request batches at the extremes and on the head track have results known up front
        dir_tab[0]  = dir_row(0, 16'd0,     16'd0,     1, 1, 16'd0,     16'd0,     21'd0);
        dir_tab[1]  = dir_row(1, 16'd65535, 16'd0,     1, 1, 16'd0,     16'd65535, 21'd65535);
        dir_tab[2]  = dir_row(1, 16'd0,     16'd65535, 1, 1, 16'd65535, 16'd65535, 21'd65535);
        dir_tab[3]  = dir_row(1, 16'd12345, 16'd12345, 1, 1, 16'd12345, 16'd0,     21'd0);
        // equal distance on both sides: earliest entry wins
        dir_tab[4]  = dir_row(1, 16'd100,   16'd110,   0, 0, '0, '0, '0);
        dir_tab[5]  = dir_row(0, 16'd0,     16'd90,    1, 0, '0, '0, '0);
        // order depends on the front entry filling the taken slot
        dir_tab[6]  = dir_row(1, 16'd0,     16'd50,    0, 0, '0, '0, '0);
        dir_tab[7]  = dir_row(0, 16'd0,     16'd10,    0, 0, '0, '0, '0);
        dir_tab[8]  = dir_row(0, 16'd0,     16'd60,    0, 0, '0, '0, '0);
        dir_tab[9]  = dir_row(0, 16'd0,     16'd5,     0, 0, '0, '0, '0);
        dir_tab[10] = dir_row(0, 16'd0,     16'd55,    1, 0, '0, '0, '0);
        // duplicates and both ends from mid-disk
        dir_tab[11] = dir_row(1, 16'd32768, 16'd65535, 0, 0, '0, '0, '0);
        dir_tab[12] = dir_row(0, 16'd0,     16'd0,     0, 0, '0, '0, '0);
        dir_tab[13] = dir_row(0, 16'd0,     16'd32768, 0, 0, '0, '0, '0);
        dir_tab[14] = dir_row(0, 16'd0,     16'd32768, 1, 0, '0, '0, '0);
        // sweep from the top track
        dir_tab[15] = dir_row(1, 16'd65535, 16'd1,     0, 0, '0, '0, '0);
        dir_tab[16] = dir_row(0, 16'd0,     16'd2,     0, 0, '0, '0, '0);
        dir_tab[17] = dir_row(0, 16'd0,     16'd65534, 1, 0, '0, '0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].wr_cfg)
                write_start_head(dir_tab[r].cfg_val);
            pace();
            send_item(dir_tab[r].trk, dir_tab[r].last, dir_tab[r].typed, dir_tab[r].res);
        end

        // random batches, one start_head setting per phase
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       phase_head = 16'd0;
                1:       phase_head = 16'd65535;
                2:       phase_head = track_t'($urandom);
                default: phase_head = 16'd32768;
            endcase
            write_start_head(phase_head);
            quiet = (p == 3);
            phase_items = 0;
            while (phase_items < 32) begin
                if (phase_items == 0 && p == 0)
                    len = 34;                       // overflow: extra requests dropped
                else if (phase_items == 0 && p == 1)
                    len = 32;                       // exactly full store
                else if ($urandom_range(0, 9) < 7)
                    len = $urandom_range(1, 6);
                else
                    len = $urandom_range(7, 16);
                run_batch(len, sent);
                phase_items += sent;
                // hold off once until the block has emptied
                if (p == 2 && phase_items == sent)
                    drain_results();
            end
        end

        // wind down
        drain_results();
        repeat (40) @(posedge clk);
        if (errors == 0 && service_q.size() == 0)
            $display("shortest_seek_first_order_test: done, clean");
        else
            $display("shortest_seek_first_order_test: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
src/sstf_pkg.sv
src/sstf_scan.sv
src/shortest_seek_first_order.sv
bench/shortest_seek_first_order_test.sv
